>>> design/assert_macros.svh
// Assertion helpers shared by the design modules.
// Every macro samples on the rising edge of clk and is held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define DNGR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define DNGR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> design/dngr_pkg.sv
package dngr_pkg;

  // These are the states of the row sequencer.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_EMIT
  } dngr_state_t;

  // These are the commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic split;
    logic emit;
    logic next_digit;
  } dngr_cmd_t;

  // This is the status from the datapath to the controller.
  typedef struct packed {
    logic row_last;
    logic digit_last;
    logic out_free;
  } dngr_stat_t;

  localparam int GLYPH_H = 7;
  localparam int GLYPH_W = 5;

  // Index of the bottom font row.
  localparam logic [2:0] ROW_LAST = 3'(GLYPH_H - 1);

  // Powers of ten that set the digit count, up to four digits.
  localparam logic [13:0] DEC_POW [4] = '{14'd1, 14'd10, 14'd100, 14'd1000};

  // This is the reciprocal of ten in 16 fraction bits. It is exact for values below 16384.
  localparam logic [12:0] RECIP10 = 13'd6554;

  // This is the 5x7 digit font. Bit 4 of each row is the leftmost pixel.
  localparam logic [4:0] GLYPH_ROM [10][GLYPH_H] = '{
    '{5'h1F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1F},
    '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h1F, 5'h01, 5'h01, 5'h1F, 5'h10, 5'h10, 5'h1F},
    '{5'h1F, 5'h01, 5'h01, 5'h0F, 5'h01, 5'h01, 5'h1F},
    '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h01, 5'h01, 5'h01},
    '{5'h1F, 5'h10, 5'h10, 5'h1F, 5'h01, 5'h01, 5'h1F},
    '{5'h1F, 5'h10, 5'h10, 5'h1F, 5'h11, 5'h11, 5'h1F},
    '{5'h1F, 5'h01, 5'h01, 5'h02, 5'h04, 5'h04, 5'h04},
    '{5'h1F, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h1F},
    '{5'h1F, 5'h11, 5'h11, 5'h1F, 5'h01, 5'h01, 5'h1F}
  };

  // This looks up one font row. Codes above nine show as blank.
  function automatic logic [4:0] glyph_row(input logic [3:0] digit, input logic [2:0] row);
    logic [4:0] mask;
    mask = 5'h00;
    if (digit <= 4'd9 && row <= ROW_LAST) begin
      mask = GLYPH_ROM[digit][row];
    end
    return mask;
  endfunction

endpackage

>>> design/dngr_ctrl.sv
module dngr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output dngr_pkg::dngr_cmd_t cmd,
  input  dngr_pkg::dngr_stat_t stat
);
  import dngr_pkg::*;
  `include "assert_macros.svh"

  dngr_state_t state_r;
  dngr_state_t state_nxt;

  // This is the state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands: one row goes out per cycle when the output register is free.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.row_last) begin
            if (stat.digit_last) begin
              state_nxt = ST_IDLE;
            end else begin
              cmd.split      = 1'b1;
              cmd.next_digit = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // A row must never overwrite a result that is still waiting downstream.
  `DNGR_ASSERT_IMP(a_emit_free, cmd.emit, stat.out_free, "row emitted into a busy output register")

endmodule

>>> design/dngr_datapath.sv
module dngr_datapath #(
  parameter int SCALE      = 2,
  parameter int MAX_DIGITS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic signed [10:0]   in_x_pos,
  input  logic signed [10:0]   in_y_pos,
  input  logic [13:0]          in_number,
  input  logic [15:0]          in_color,
  input  dngr_pkg::dngr_cmd_t  cmd,
  output dngr_pkg::dngr_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [11:0]   out_x_left,
  output logic signed [11:0]   out_y_row,
  output logic [4:0]           out_row_mask,
  output logic [15:0]          out_pixel_color,
  output logic                 out_last
);
  import dngr_pkg::*;
  `include "assert_macros.svh"

  localparam int          DW       = $clog2(MAX_DIGITS + 1);
  localparam logic [13:0] SAT_MAX  = 14'(10 ** MAX_DIGITS - 1);
  localparam logic [11:0] STRIDE   = 12'((GLYPH_W + 1) * SCALE);
  localparam logic [11:0] OFFSET   = 12'(GLYPH_W * SCALE);
  localparam logic [11:0] Y_STEP   = 12'(SCALE);

  logic [13:0]   sat_value;
  logic [DW-1:0] ndig_in;
  logic [11:0]   span;
  logic [11:0]   x_start;
  logic [26:0]   prod;
  logic [13:0]   quot;
  logic [13:0]   quot10;
  logic [13:0]   rem;

  logic [13:0]   val_r;
  logic [3:0]    digit_r;
  logic [2:0]    row_r;
  logic [DW-1:0] dig_cnt_r;
  logic [DW-1:0] ndig_r;
  logic [11:0]   x_cur_r;
  logic [11:0]   y_top_r;
  logic [11:0]   y_cur_r;
  logic [15:0]   color_r;

  logic          out_valid_r;
  logic [11:0]   out_x_left_r;
  logic [11:0]   out_y_row_r;
  logic [4:0]    out_row_mask_r;
  logic [15:0]   out_color_r;
  logic          out_last_r;

  // Saturate the value and count its decimal digits; zero counts as one digit.
  always_comb begin
    sat_value = (in_number > SAT_MAX) ? SAT_MAX : in_number;
    ndig_in   = DW'(1);
    for (int k = 1; k < MAX_DIGITS; k++) begin
      if (sat_value >= DEC_POW[2'(k)]) begin
        ndig_in = ndig_in + DW'(1);
      end
    end
  end

  // The least significant digit sits in the rightmost cell.
  assign span    = 12'(ndig_in - DW'(1)) * STRIDE;
  assign x_start = {in_x_pos[10], in_x_pos} + span - OFFSET;

  // Peel off one decimal digit by a reciprocal multiply.
  assign prod   = 27'(val_r) * 27'(RECIP10);
  assign quot   = 14'(prod >> 16);
  assign quot10 = 14'(quot * 14'd10);
  assign rem    = val_r - quot10;

  // These are the status flags for the controller.
  assign stat.row_last   = (row_r == ROW_LAST);
  assign stat.digit_last = (dig_cnt_r == ndig_r - DW'(1));
  assign stat.out_free   = !out_valid_r || !out_stall;

  // These are the sequencer counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      dig_cnt_r <= '0;
      ndig_r    <= DW'(1);
    end else begin
      if (cmd.load) begin
        row_r     <= '0;
        dig_cnt_r <= '0;
        ndig_r    <= ndig_in;
      end else begin
        if (cmd.emit) begin
          row_r <= stat.row_last ? 3'd0 : row_r + 3'd1;
        end
        if (cmd.next_digit) begin
          dig_cnt_r <= dig_cnt_r + DW'(1);
        end
      end
    end
  end

  // This is the working state of the current transaction.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r   <= sat_value;
      x_cur_r <= x_start;
      y_top_r <= {in_y_pos[10], in_y_pos};
      y_cur_r <= {in_y_pos[10], in_y_pos};
      color_r <= in_color;
    end else begin
      if (cmd.split) begin
        digit_r <= rem[3:0];
        val_r   <= quot;
      end
      if (cmd.next_digit) begin
        x_cur_r <= x_cur_r - STRIDE;
      end
      if (cmd.emit) begin
        y_cur_r <= stat.row_last ? y_top_r : y_cur_r + Y_STEP;
      end
    end
  end

  // The output register holds a row until the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x_left_r   <= x_cur_r;
      out_y_row_r    <= y_cur_r;
      out_row_mask_r <= glyph_row(digit_r, row_r);
      out_color_r    <= color_r;
      out_last_r     <= stat.row_last && stat.digit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x_left      = out_x_left_r;
  assign out_y_row       = out_y_row_r;
  assign out_row_mask    = out_row_mask_r;
  assign out_pixel_color = out_color_r;
  assign out_last        = out_last_r;

  // The counters must stay inside the glyph and the digit count.
  `DNGR_ASSERT(a_row_range, row_r <= ROW_LAST, "font row index out of range")
  `DNGR_ASSERT(a_digit_range, dig_cnt_r < ndig_r, "digit index beyond digit count")

endmodule

>>> design/decimal_number_glyph_rows.sv
// This block renders a decimal number as 5x7 font rows. An input transaction carries an
// anchor x, a top y, a value and a color. The value is saturated to 10^MAX_DIGITS - 1, and
// zero shows as one digit. The block returns seven row transactions per digit, least
// significant digit first, top row first. Cells step 6*SCALE pixels apart, and the least
// significant cell lies furthest right. The last flag marks the bottom row of the most
// significant digit. The sequencer accepts a transaction in ST_IDLE, extracts its first
// digit in ST_SPLIT, then emits the rows in ST_EMIT while the output register is free. Later
// digits are extracted in the cycle of the previous digit's bottom row. A new input is taken
// as soon as the final row has entered the output register.
module decimal_number_glyph_rows #(
  parameter int SCALE      = 2,
  parameter int MAX_DIGITS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [10:0] in_x_pos,
  input  logic signed [10:0] in_y_pos,
  input  logic [13:0]        in_number,
  input  logic [15:0]        in_color,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [11:0] out_x_left,
  output logic signed [11:0] out_y_row,
  output logic [4:0]         out_row_mask,
  output logic [15:0]        out_pixel_color,
  output logic               out_last
);
  import dngr_pkg::*;

  dngr_cmd_t  cmd;
  dngr_stat_t stat;

  // This is the row sequencer.
  dngr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // This holds digit extraction, coordinates and the output register.
  dngr_datapath #(
    .SCALE      (SCALE),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_x_pos        (in_x_pos),
    .in_y_pos        (in_y_pos),
    .in_number       (in_number),
    .in_color        (in_color),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x_left      (out_x_left),
    .out_y_row       (out_y_row),
    .out_row_mask    (out_row_mask),
    .out_pixel_color (out_pixel_color),
    .out_last        (out_last)
  );

endmodule
